[rtl/srt_pkg.sv]
// Package for the shift-register random table: sizes, register reset value,
// generator step, control word layout and the sequencer program ROM.
// Used by srt_seq, srt_datapath and shift_register_random_table.
package srt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 8);
	localparam int STEPS_PER_CYCLE = 8;
	localparam int SUB_LAST = 64 / STEPS_PER_CYCLE - 1;
	localparam int SW = $clog2(64 / STEPS_PER_CYCLE);

	localparam logic [63:0] SEED_RESET  = 64'h91AB_2489_80B1_09E8;
	localparam logic [63:0] PATCH_MASK0 = 64'hFFFF_FFFF_FFFF_FFFE;
	localparam logic [63:0] PATCH_BIT0  = 64'h8000_0000_0000_0000;

	localparam logic FUNC_REBUILD = 1'b0;
	localparam logic FUNC_READ    = 1'b1;

	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_ACCEPT = 4'd1;
	localparam logic [3:0] OP_LOAD   = 4'd2;
	localparam logic [3:0] OP_STEP   = 4'd3;
	localparam logic [3:0] OP_STORE  = 4'd4;
	localparam logic [3:0] OP_PINIT  = 4'd5;
	localparam logic [3:0] OP_PRD    = 4'd6;
	localparam logic [3:0] OP_PWR    = 4'd7;
	localparam logic [3:0] OP_DONE   = 4'd8;
	localparam logic [3:0] OP_RD     = 4'd9;
	localparam logic [3:0] OP_RRET   = 4'd10;

	localparam logic [2:0] COND_NONE   = 3'd0;
	localparam logic [2:0] COND_ALWAYS = 3'd1;
	localparam logic [2:0] COND_READ   = 3'd2;
	localparam logic [2:0] COND_SUB    = 3'd3;
	localparam logic [2:0] COND_FILL   = 3'd4;
	localparam logic [2:0] COND_PATCH  = 3'd5;

	localparam logic [3:0] PC_IDLE  = 4'd0;
	localparam logic [3:0] PC_LOAD  = 4'd1;
	localparam logic [3:0] PC_GEN   = 4'd2;
	localparam logic [3:0] PC_STORE = 4'd3;
	localparam logic [3:0] PC_PINIT = 4'd4;
	localparam logic [3:0] PC_PRD   = 4'd5;
	localparam logic [3:0] PC_PWR   = 4'd6;
	localparam logic [3:0] PC_DONE  = 4'd7;
	localparam logic [3:0] PC_RD    = 4'd8;
	localparam logic [3:0] PC_RRET  = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic       wait_in;
		logic       wait_out;
		logic [2:0] cond;
		logic [3:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic [3:0] op;
		logic       en;
	} dp_ctrl_t;

	typedef struct packed {
		logic func_read;
		logic sub_more;
		logic fill_more;
		logic patch_more;
		logic out_busy;
	} dp_status_t;

	function automatic logic [63:0] gen_step8(input logic [63:0] r_in);
		logic [63:0] r;
		logic        fb;
		r = r_in;
		for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
			fb = r[0] ^ r[1] ^ r[2] ^ r[3] ^ r[5] ^ r[7];
			r = {r[0], r[63:2], fb};
		end
		return r;
	endfunction

	function automatic ctrl_word_t prog_rom(input logic [3:0] pc);
		ctrl_word_t w;
		case (pc)
			PC_IDLE:  w = '{OP_ACCEPT, 1'b1, 1'b0, COND_READ,   PC_RD};
			PC_LOAD:  w = '{OP_LOAD,   1'b0, 1'b0, COND_NONE,   PC_IDLE};
			PC_GEN:   w = '{OP_STEP,   1'b0, 1'b0, COND_SUB,    PC_GEN};
			PC_STORE: w = '{OP_STORE,  1'b0, 1'b0, COND_FILL,   PC_GEN};
			PC_PINIT: w = '{OP_PINIT,  1'b0, 1'b0, COND_NONE,   PC_IDLE};
			PC_PRD:   w = '{OP_PRD,    1'b0, 1'b0, COND_NONE,   PC_IDLE};
			PC_PWR:   w = '{OP_PWR,    1'b0, 1'b0, COND_PATCH,  PC_PRD};
			PC_DONE:  w = '{OP_DONE,   1'b0, 1'b1, COND_ALWAYS, PC_IDLE};
			PC_RD:    w = '{OP_RD,     1'b0, 1'b0, COND_NONE,   PC_IDLE};
			PC_RRET:  w = '{OP_RRET,   1'b0, 1'b1, COND_ALWAYS, PC_IDLE};
			default:  w = '{OP_NOP,    1'b0, 1'b0, COND_ALWAYS, PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/srt_seq.sv]
// Microcode sequencer: step counter, program ROM lookup, stall and jump logic.
// Depends on srt_pkg.
module srt_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  srt_pkg::dp_status_t   status,
	output srt_pkg::dp_ctrl_t     ctrl
);

	logic [3:0]          pc_q;
	srt_pkg::ctrl_word_t w;
	logic                stall;
	logic                jump;

	assign w        = srt_pkg::prog_rom(pc_q);
	assign in_ready = (pc_q == srt_pkg::PC_IDLE);
	assign stall    = (w.wait_in && !(in_valid && in_ready)) || (w.wait_out && status.out_busy);

	always_comb begin
		case (w.cond)
			srt_pkg::COND_NONE:   jump = 1'b0;
			srt_pkg::COND_ALWAYS: jump = 1'b1;
			srt_pkg::COND_READ:   jump = status.func_read;
			srt_pkg::COND_SUB:    jump = status.sub_more;
			srt_pkg::COND_FILL:   jump = status.fill_more;
			srt_pkg::COND_PATCH:  jump = status.patch_more;
			default:              jump = 1'b1;
		endcase
	end

	assign ctrl.op = w.op;
	assign ctrl.en = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= srt_pkg::PC_IDLE;
		end else if (!stall) begin
			pc_q <= jump ? w.target : pc_q + 4'd1;
		end
	end

endmodule

[rtl/srt_datapath.sv]
// Datapath: seed register, generator, counters, table memory, output register.
// Depends on srt_pkg; driven by the control word from srt_seq.
module srt_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srt_pkg::dp_ctrl_t     ctrl,
	output srt_pkg::dp_status_t   status,
	input  logic                  seed_we,
	input  logic [63:0]           seed_wdata,
	input  logic                  in_func,
	input  logic [7:0]            in_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           out_value,
	output logic                  out_done
);

	logic [63:0]             seed_q;
	logic [63:0]             gen_q;
	logic [srt_pkg::SW-1:0]  sub_q;
	logic [srt_pkg::NW-1:0]  n_q;
	logic [5:0]              k_q;
	logic [63:0]             bit_q;
	logic [63:0]             mask_q;
	logic [7:0]              idx_q;
	logic [63:0]             mem_q [srt_pkg::TABLE_DEPTH];
	logic [63:0]             rdata_q;
	logic                    out_valid_q;
	logic [63:0]             value_q;
	logic                    done_q;
	logic                    go;
	logic                    load_out;
	logic                    in_range;
	logic [srt_pkg::AW-1:0]  rd_addr;

	assign go       = ctrl.en;
	assign load_out = go && (ctrl.op == srt_pkg::OP_DONE || ctrl.op == srt_pkg::OP_RRET);
	assign in_range = (32'(idx_q) < srt_pkg::TABLE_DEPTH);
	assign rd_addr  = (ctrl.op == srt_pkg::OP_RD) ? srt_pkg::AW'(idx_q) : n_q[srt_pkg::AW-1:0];

	assign status.func_read  = (in_func == srt_pkg::FUNC_READ);
	assign status.sub_more   = (sub_q != srt_pkg::SW'(srt_pkg::SUB_LAST));
	assign status.fill_more  = (n_q != srt_pkg::NW'(srt_pkg::TABLE_DEPTH - 1));
	assign status.patch_more = ((n_q + srt_pkg::NW'(7)) < srt_pkg::NW'(srt_pkg::TABLE_DEPTH))
		&& (k_q != 6'd63);
	assign status.out_busy   = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= srt_pkg::SEED_RESET;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q  <= '0;
			sub_q  <= '0;
			n_q    <= '0;
			k_q    <= '0;
			bit_q  <= '0;
			mask_q <= '0;
			idx_q  <= '0;
		end else if (go) begin
			case (ctrl.op)
				srt_pkg::OP_ACCEPT: begin
					idx_q <= in_index;
				end
				srt_pkg::OP_LOAD: begin
					gen_q <= seed_q;
					sub_q <= '0;
					n_q   <= '0;
				end
				srt_pkg::OP_STEP: begin
					gen_q <= srt_pkg::gen_step8(gen_q);
					sub_q <= sub_q + srt_pkg::SW'(1);
				end
				srt_pkg::OP_STORE: begin
					sub_q <= '0;
					n_q   <= n_q + srt_pkg::NW'(1);
				end
				srt_pkg::OP_PINIT: begin
					n_q    <= srt_pkg::NW'(3);
					k_q    <= '0;
					bit_q  <= srt_pkg::PATCH_BIT0;
					mask_q <= srt_pkg::PATCH_MASK0;
				end
				srt_pkg::OP_PWR: begin
					n_q    <= n_q + srt_pkg::NW'(7);
					k_q    <= k_q + 6'd1;
					bit_q  <= bit_q >> 1;
					mask_q <= mask_q >> 1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.op == srt_pkg::OP_STORE) begin
			mem_q[n_q[srt_pkg::AW-1:0]] <= gen_q;
		end else if (go && ctrl.op == srt_pkg::OP_PWR) begin
			mem_q[n_q[srt_pkg::AW-1:0]] <= bit_q | (rdata_q & mask_q);
		end
		if (go && (ctrl.op == srt_pkg::OP_RD || ctrl.op == srt_pkg::OP_PRD)) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (ctrl.op == srt_pkg::OP_DONE) begin
				value_q <= '0;
				done_q  <= 1'b1;
			end else begin
				value_q <= in_range ? rdata_q : '0;
				done_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = value_q;
	assign out_done  = done_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten while held");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctrl.op == srt_pkg::OP_DONE) |=> (out_valid_q && done_q && value_q == '0))
		else $error("rebuild result not presented");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctrl.op == srt_pkg::OP_RRET) |=> (out_valid_q && !done_q))
		else $error("read result not presented");

endmodule

[rtl/shift_register_random_table.sv]
// Top level of the shift-register random table: streaming ports and the
// seed register write port. Instantiates srt_seq and srt_datapath; uses srt_pkg.
//
// Usage: one input transaction on s_* gives exactly one result transaction on m_*.
// s_tuser is the function: 0 rebuilds the table from the seed, 1 reads the entry
// at s_tdata. A rebuild answers with m_tdata zero and m_tuser 1; a read answers
// with the stored word and m_tuser 0 (zero when the index lies past the table).
// The seed is written with seed_we/seed_wdata while the block is idle.
// Items are handled one at a time by a microcoded sequencer; s_tready is high
// only in the idle step. A read passes an address step and a result step before
// its result is registered; the next item is taken only back in the idle step.
// A rebuild runs 8 generator steps per cycle and stores each table word in turn,
// then patches every seventh entry from entry 3 on, each by a read and a write step:
// P = min(64, ceil((TABLE_DEPTH-3)/7)) patched entries, i.e. 37 for 256 entries.
// A finished result waits in an output register; the next transaction is
// taken meanwhile, and the sequencer holds at its result step while m_tready
// stays low. Reset clears the sequencer and output valid and restores the
// default seed; table contents are undefined until the first rebuild.
module shift_register_random_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] index
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value
	output logic        m_tuser,   // [0] done_res
	input  logic        seed_we,
	input  logic [63:0] seed_wdata
);

	srt_pkg::dp_ctrl_t   ctrl;
	srt_pkg::dp_status_t status;

	srt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.ctrl     (ctrl)
	);

	srt_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.in_func    (s_tuser),
		.in_index   (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_done   (m_tuser)
	);

endmodule

[bench/shift_register_random_table_tb.sv]
// Testbench for shift_register_random_table: drives rebuild and read transactions,
// writes the seed between phases and checks every result against a table predictor.
// Depends on srt_pkg and the shift_register_random_table RTL.
`timescale 1ns / 1ps

module shift_register_random_table_tb;

	localparam int   STALL_LIMIT  = 20000;
	localparam int   PHASE_ITEMS  = 580;
	localparam int   HOLD_CYCLES  = 400;

	class table_scoreboard;
		logic [63:0] seed_reg;
		logic [63:0] words [srt_pkg::TABLE_DEPTH];
		logic [63:0] value_q [$];
		logic        done_q [$];
		int          errors;

		function new();
			seed_reg = srt_pkg::SEED_RESET;
			errors = 0;
			foreach (words[i]) words[i] = '0;
		endfunction

		function logic [63:0] next_word(logic [63:0] r);
			logic fb;
			for (int i = 0; i < 64; i++) begin
				fb = r[0] ^ r[1] ^ r[2] ^ r[3] ^ r[5] ^ r[7];
				r = ({r[0], r[63:1]} & srt_pkg::PATCH_MASK0) | {63'd0, fb};
			end
			return r;
		endfunction

		function void rebuild_words();
			logic [63:0] gen;
			int          pos;
			gen = seed_reg;
			for (int n = 0; n < srt_pkg::TABLE_DEPTH; n++) begin
				gen = next_word(gen);
				words[n] = gen;
			end
			pos = 3;
			for (int k = 0; k < 64 && pos < srt_pkg::TABLE_DEPTH; k++) begin
				words[pos] = (srt_pkg::PATCH_BIT0 >> k)
					| (words[pos] & (srt_pkg::PATCH_MASK0 >> k));
				pos += 7;
			end
		endfunction

		function void note_item(logic func, logic [7:0] idx);
			if (func == srt_pkg::FUNC_REBUILD) begin
				rebuild_words();
				value_q.push_back('0);
				done_q.push_back(1'b1);
			end else begin
				value_q.push_back(int'(idx) < srt_pkg::TABLE_DEPTH ? words[idx] : 64'd0);
				done_q.push_back(1'b0);
			end
		endfunction

		function void check_result(logic [63:0] value, logic done_res);
			logic [63:0] exp_value;
			logic        exp_done;
			if (value_q.size() == 0) begin
				$error("unexpected result: value %h done_res %b", value, done_res);
				errors++;
				return;
			end
			exp_value = value_q.pop_front();
			exp_done = done_q.pop_front();
			if (value !== exp_value) begin
				$error("value: expected %h, actual %h", exp_value, value);
				errors++;
			end
			if (done_res !== exp_done) begin
				$error("done_res: expected %b, actual %b", exp_done, done_res);
				errors++;
			end
		endfunction

		function int pending();
			return value_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        seed_we;
	logic [63:0] seed_wdata;

	table_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int stall_cycles;

	shift_register_random_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("shift_register_random_table_tb NOT OK");
			$finish;
		end
	end

	// hold off the receiver for a long stretch when requested
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input logic func, input logic [7:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= idx;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] value);
		drain();
		repeat (4) @(negedge clk);
		seed_we <= 1'b1;
		seed_wdata <= value;
		sb.seed_reg = value;
		@(negedge clk);
		seed_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(149) == 0) begin
				send_item(srt_pkg::FUNC_REBUILD, 8'($urandom));
			end else begin
				send_item(srt_pkg::FUNC_READ, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = srt_pkg::FUNC_REBUILD;
		seed_we = 1'b0;
		seed_wdata = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		send_item(srt_pkg::FUNC_REBUILD, 8'h00);
		send_item(srt_pkg::FUNC_READ, 8'd0);
		send_item(srt_pkg::FUNC_READ, 8'd255);
		send_item(srt_pkg::FUNC_READ, 8'd3);
		send_item(srt_pkg::FUNC_READ, 8'd10);
		send_item(srt_pkg::FUNC_READ, 8'd17);
		send_item(srt_pkg::FUNC_READ, 8'd252);
		send_item(srt_pkg::FUNC_READ, 8'd128);
		send_item(srt_pkg::FUNC_READ, 8'h55);
		send_item(srt_pkg::FUNC_READ, 8'hAA);
		write_seed(64'd0);
		send_item(srt_pkg::FUNC_REBUILD, 8'hFF);
		send_item(srt_pkg::FUNC_READ, 8'd0);
		send_item(srt_pkg::FUNC_READ, 8'd3);
		send_item(srt_pkg::FUNC_READ, 8'd255);
		write_seed({64{1'b1}});
		send_item(srt_pkg::FUNC_REBUILD, 8'h5A);
		send_item(srt_pkg::FUNC_READ, 8'd0);
		send_item(srt_pkg::FUNC_READ, 8'd3);
		send_item(srt_pkg::FUNC_READ, 8'd254);
		send_item(srt_pkg::FUNC_READ, 8'd255);

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 38 : (p == 1) ? 72 : 0;
			recv_idle_pct = (p == 0) ? 72 : (p == 1) ? 38 : 0;
			write_seed({$urandom, $urandom});
			send_item(srt_pkg::FUNC_REBUILD, 8'($urandom));
			if (p == 2) begin
				send_item(srt_pkg::FUNC_READ, 8'($urandom_range(255)));
				hold_req = 1'b1;
			end
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("shift_register_random_table_tb OK");
		end else begin
			$display("shift_register_random_table_tb NOT OK");
		end
		$finish;
	end

endmodule
